/* rtl/tcw_pkg.sv */
// Shared types and constants of the text console cell writer.
`default_nettype none
package tcw_pkg;

	localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
	localparam logic [2:0] CMD_SET_COLOR  = 3'd1;
	localparam logic [2:0] CMD_SET_CURSOR = 3'd2;
	localparam logic [2:0] CMD_CLEAR      = 3'd3;
	localparam logic [2:0] CMD_READ_CELL  = 3'd4;

	localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
	localparam logic [7:0]  CH_BACKSPACE = 8'h08;
	localparam logic [7:0]  CH_BLANK     = 8'h20;
	localparam logic [31:0] WHITE_PIXEL  = 32'h00FF_FFFF;
	localparam logic [31:0] BLACK_PIXEL  = 32'h0000_0000;
	localparam logic [1:0]  FULL_CLEAR   = 2'd2;

	localparam logic [1:0] REG_COLUMNS    = 2'd0;
	localparam logic [1:0] REG_ROWS       = 2'd1;
	localparam logic [1:0] REG_BACKGROUND = 2'd2;

	localparam logic [7:0]  COLUMNS_RESET    = 8'd75;
	localparam logic [6:0]  ROWS_RESET       = 7'd50;
	localparam logic [31:0] BACKGROUND_RESET = 32'd0;

	localparam int PADDR_W = 4;
	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 88;
	localparam int CELL_W = 72;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_COLOR,
		OP_CURSOR,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  value_byte;
		logic [7:0]  row_index;
		logic [31:0] color;
	} op_req_t;

	// effective sizes, already clamped to 1..maximum
	typedef struct packed {
		logic [8:0]  cols;
		logic [7:0]  rows;
		logic [31:0] bg;
		logic        fit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_CLEAR,
		ST_DONE
	} back_state_t;

endpackage
`default_nettype wire

/* rtl/text_console_cell_writer.sv */
// Top level of the text console cell writer.
//
//  channel  dir  handshake                 payload
//  s_       in   s_tvalid / s_tready       s_tuser command, s_tdata operands
//  m_       out  m_tvalid / m_tready       m_tdata cursor and cell read back
//  apb      in   psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// Ordinary requests: queue pop, then result load once the result register is free.
// Moving past the last row, by line feed or wrap, first blanks the oldest line.
// Clear mode 2 sweeps the whole store, MAX_ROWS*MAX_COLUMNS cells, one cell a cycle.
// After reset a similar sweep writes white-on-black blanks with s_tready low.
// A two-entry queue lets the input side keep accepting while a result waits on m_tready.
`default_nettype none
module text_console_cell_writer #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// value_byte[7:0], row_index[15:8], color[47:16], clear_mode[49:48]
	input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
	// command[2:0]
	input  wire logic [tcw_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// cursor_row[5:0], cursor_col[12:6], cell_glyph[20:13], cell_fg[52:21], cell_bg[84:53]
	output logic [tcw_pkg::M_TDATA_W-1:0]      m_tdata,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcw_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import tcw_pkg::*;

	cfg_t    cfg;
	op_req_t req;
	logic    req_valid;
	logic    req_ready;
	logic    init_busy;

	tcw_regs #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	tcw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.init_busy(init_busy),
		.req_valid(req_valid),
		.req(req),
		.req_ready(req_ready)
	);

	tcw_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req_valid(req_valid),
		.req(req),
		.req_ready(req_ready),
		.init_busy(init_busy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule
`default_nettype wire

/* rtl/tcw_regs.sv */
// Configuration registers behind the APB-style port.
`default_nettype none
module tcw_regs #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output tcw_pkg::cfg_t                    cfg
);
	import tcw_pkg::*;

	logic [7:0]  columns_q;
	logic [6:0]  rows_q;
	logic [31:0] background_q;
	logic        fit_q;
	logic        wr;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign idx = paddr[3:2];
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q <= ROWS_RESET;
			background_q <= BACKGROUND_RESET;
			fit_q <= 1'b0;
		end else begin
			fit_q <= wr && (idx == REG_COLUMNS || idx == REG_ROWS);
			if (wr) begin
				case (idx)
					REG_COLUMNS: columns_q <= pwdata[7:0];
					REG_ROWS: rows_q <= pwdata[6:0];
					REG_BACKGROUND: background_q <= pwdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_COLUMNS: prdata = {24'd0, columns_q};
			REG_ROWS: prdata = {25'd0, rows_q};
			REG_BACKGROUND: prdata = background_q;
			default: prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (columns_q == 8'd0) begin
			cfg.cols = 9'd1;
		end else if (9'(columns_q) > 9'(MAX_COLUMNS)) begin
			cfg.cols = 9'(MAX_COLUMNS);
		end else begin
			cfg.cols = 9'(columns_q);
		end
		if (rows_q == 7'd0) begin
			cfg.rows = 8'd1;
		end else if (8'(rows_q) > 8'(MAX_ROWS)) begin
			cfg.rows = 8'(MAX_ROWS);
		end else begin
			cfg.rows = 8'(rows_q);
		end
		cfg.bg = background_q;
		cfg.fit = fit_q;
	end

endmodule
`default_nettype wire

/* rtl/tcw_front.sv */
// Input stage: accept requests, classify them and queue them for the back end.
`default_nettype none
module tcw_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [tcw_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                          init_busy,
	output logic                               req_valid,
	output tcw_pkg::op_req_t                   req,
	input  wire logic                          req_ready
);
	import tcw_pkg::*;

	op_req_t            queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	op_req_t            dec;
	logic [7:0]         vb;
	logic [1:0]         mode;
	logic               push;
	logic               pop;

	assign vb = s_tdata[7:0];
	assign mode = s_tdata[49:48];

	always_comb begin
		dec.value_byte = vb;
		dec.row_index = s_tdata[15:8];
		dec.color = s_tdata[47:16];
		case (s_tuser)
			CMD_PUT_CHAR: begin
				if (vb == CH_NEWLINE) begin
					dec.op = OP_NEWLINE;
				end else if (vb == CH_BACKSPACE) begin
					dec.op = OP_BACKSPACE;
				end else begin
					dec.op = OP_PUT;
				end
			end
			CMD_SET_COLOR: dec.op = OP_COLOR;
			CMD_SET_CURSOR: dec.op = OP_CURSOR;
			CMD_CLEAR: dec.op = (mode == FULL_CLEAR) ? OP_CLEAR : OP_NOP;
			CMD_READ_CELL: dec.op = OP_READ;
			default: dec.op = OP_NOP;
		endcase
	end

	assign s_tready = (count_q != QCNT_W'(QUEUE_DEPTH)) && !init_busy;
	assign push = s_tvalid && s_tready;
	assign req_valid = (count_q != '0);
	assign req = queue_q[rd_ptr_q];
	assign pop = req_valid && req_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/tcw_back.sv */
// Back end: cursor, ring top line, cell store, blanking sweeps and result register.
`default_nettype none
module tcw_back #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tcw_pkg::cfg_t               cfg,
	input  wire logic                        req_valid,
	input  wire tcw_pkg::op_req_t            req,
	output logic                             req_ready,
	output logic                             init_busy,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata
);
	import tcw_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW = $clog2(DEPTH);
	localparam int CPW = $clog2(MAX_COLUMNS);
	localparam int RPW = $clog2(MAX_ROWS);

	back_state_t          state_q, state_d;
	logic [CPW-1:0]       col_q, col_d;
	logic [RPW-1:0]       row_q, row_d;
	logic [RPW-1:0]       top_q, top_d;
	logic [31:0]          pen_q, pen_d;
	logic [CPW-1:0]       scan_q, scan_d;
	logic [AW-1:0]        idx_q, idx_d;
	logic                 hit_q, hit_d;
	logic [CELL_W-1:0]    store_mem [DEPTH];
	logic [CELL_W-1:0]    rdata_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [CELL_W-1:0]    mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic                 out_free;
	logic                 out_load;
	logic [RPW-1:0]       cur_prow;
	logic                 row_inc;
	logic [CELL_W-1:0]    blank_cell;

	function automatic logic [RPW-1:0] phys_row(input logic [RPW-1:0] top,
			input logic [RPW-1:0] view, input logic [7:0] rows);
		logic [7:0] sum;
		sum = 8'(top) + 8'(view);
		if (sum >= rows) begin
			sum = sum - rows;
		end
		return RPW'(sum);
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RPW-1:0] prow,
			input logic [CPW-1:0] col);
		return AW'(prow) * AW'(MAX_COLUMNS) + AW'(col);
	endfunction

	assign init_busy = (state_q == ST_INIT);
	assign out_free = !m_tvalid_q || m_tready;
	assign cur_prow = phys_row(top_q, row_q, cfg.rows);
	assign blank_cell = {CH_BLANK, pen_q, cfg.bg};

	always_comb begin
		state_d = state_q;
		col_d = col_q;
		row_d = row_q;
		top_d = top_q;
		pen_d = pen_q;
		scan_d = scan_q;
		idx_d = idx_q;
		hit_d = hit_q;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = blank_cell;
		mem_re = 1'b0;
		mem_raddr = '0;
		req_ready = 1'b0;
		out_load = 1'b0;
		row_inc = 1'b0;

		if (cfg.fit) begin
			if (9'(col_q) >= cfg.cols) col_d = CPW'(cfg.cols - 9'd1);
			if (8'(row_q) >= cfg.rows) row_d = RPW'(cfg.rows - 8'd1);
			if (8'(top_q) >= cfg.rows) top_d = '0;
		end

		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = {CH_BLANK, WHITE_PIXEL, BLACK_PIXEL};
				idx_d = idx_q + 1'b1;
				if (idx_q == AW'(DEPTH - 1)) begin
					idx_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_DONE;
					hit_d = 1'b0;
					case (req.op)
						OP_PUT: begin
							mem_we = 1'b1;
							mem_waddr = cell_addr(cur_prow, col_q);
							mem_wdata = {req.value_byte, pen_q, cfg.bg};
							if (9'(col_q) + 9'd1 >= cfg.cols) begin
								col_d = '0;
								row_inc = 1'b1;
							end else begin
								col_d = col_q + 1'b1;
							end
						end
						OP_NEWLINE: begin
							col_d = '0;
							row_inc = 1'b1;
						end
						OP_BACKSPACE: begin
							if (col_q != '0) begin
								col_d = col_q - 1'b1;
								mem_we = 1'b1;
								mem_waddr = cell_addr(cur_prow, col_q - 1'b1);
							end
						end
						OP_COLOR: pen_d = req.color;
						OP_CURSOR: begin
							col_d = (9'(req.value_byte) >= cfg.cols) ?
								CPW'(cfg.cols - 9'd1) : CPW'(req.value_byte);
							row_d = (req.row_index >= cfg.rows) ?
								RPW'(cfg.rows - 8'd1) : RPW'(req.row_index);
						end
						OP_CLEAR: begin
							idx_d = '0;
							state_d = ST_CLEAR;
						end
						OP_READ: begin
							hit_d = (9'(req.value_byte) < cfg.cols) && (req.row_index < cfg.rows);
							mem_re = hit_d;
							mem_raddr = cell_addr(
								phys_row(top_q, RPW'(req.row_index), cfg.rows),
								CPW'(req.value_byte));
						end
						default: ;
					endcase
					if (row_inc) begin
						if (8'(row_q) + 8'd1 >= cfg.rows) begin
							scan_d = '0;
							state_d = ST_SCROLL;
						end else begin
							row_d = row_q + 1'b1;
						end
					end
				end
			end
			ST_SCROLL: begin
				mem_we = 1'b1;
				mem_waddr = cell_addr(top_q, scan_q);
				scan_d = scan_q + 1'b1;
				if (9'(scan_q) + 9'd1 >= cfg.cols) begin
					top_d = (8'(top_q) + 8'd1 >= cfg.rows) ? '0 : top_q + 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = idx_q;
				idx_d = idx_q + 1'b1;
				if (idx_q == AW'(DEPTH - 1)) begin
					idx_d = '0;
					col_d = '0;
					row_d = '0;
					top_d = '0;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			col_q <= '0;
			row_q <= '0;
			top_q <= '0;
			pen_q <= WHITE_PIXEL;
			scan_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q <= col_d;
			row_q <= row_d;
			top_q <= top_d;
			pen_q <= pen_d;
			scan_q <= scan_d;
			idx_q <= idx_d;
			hit_q <= hit_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= store_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {3'd0,
				hit_q ? rdata_q[31:0] : 32'd0,
				hit_q ? rdata_q[63:32] : 32'd0,
				hit_q ? rdata_q[71:64] : 8'd0,
				7'(col_q),
				6'(row_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	a_cursor_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_INIT && !cfg.fit) |-> (9'(col_q) < cfg.cols && 8'(row_q) < cfg.rows))
		else $error("cursor outside the configured size");

	a_top_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_INIT && !cfg.fit) |-> (8'(top_q) < cfg.rows))
		else $error("top line outside the configured rows");

	a_scroll_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL) |-> (9'(scan_q) < cfg.cols))
		else $error("scroll sweep beyond the configured columns");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("finished request did not reach the result register");

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the text console cell writer: random and directed commands, predicted results.
`default_nettype none
module testbench;
	import tcw_pkg::*;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS = 64;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLUMNS;
	localparam int SWEEP_CYCLES = CELL_COUNT + 64;
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct packed {
		logic [31:0] cell_bg;
		logic [31:0] cell_fg;
		logic [7:0]  cell_glyph;
		logic [6:0]  cursor_col;
		logic [5:0]  cursor_row;
	} console_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	text_console_cell_writer #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mirror of the console
	logic [7:0]  glyph_mem [CELL_COUNT];
	logic [31:0] fore_mem [CELL_COUNT];
	logic [31:0] back_mem [CELL_COUNT];
	logic [7:0]  columns_reg;
	logic [6:0]  rows_reg;
	logic [31:0] background_reg;
	logic [31:0] pen;
	int unsigned row_ptr;
	int unsigned col_ptr;
	int unsigned top_row;

	console_result_t pending_readbacks[$];

	bit source_idle;
	bit sink_idle;
	int hold_off_cycles = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int full_clears = 0;
	int size_settings = 0;
	int quiet_cycles = 0;

	function automatic int unsigned live_columns();
		if (columns_reg == 0) return 1;
		if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
		return columns_reg;
	endfunction

	function automatic int unsigned live_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return rows_reg;
	endfunction

	function automatic int unsigned physical_row(int unsigned view_row);
		int unsigned p;
		p = top_row + view_row;
		while (p >= live_rows()) p -= live_rows();
		return p;
	endfunction

	function automatic void paint_cell(int unsigned prow, int unsigned col, logic [7:0] glyph);
		int unsigned idx;
		idx = prow * MAX_COLUMNS + col;
		if (idx < CELL_COUNT) begin
			glyph_mem[idx] = glyph;
			fore_mem[idx] = pen;
			back_mem[idx] = background_reg;
		end
	endfunction

	function automatic void blank_store();
		int i;
		for (i = 0; i < CELL_COUNT; i++) begin
			glyph_mem[i] = CH_BLANK;
			fore_mem[i] = pen;
			back_mem[i] = background_reg;
		end
	endfunction

	function automatic void fit_cursor();
		if (col_ptr >= live_columns()) col_ptr = live_columns() - 1;
		if (row_ptr >= live_rows()) row_ptr = live_rows() - 1;
		if (top_row >= live_rows()) top_row = 0;
	endfunction

	function automatic void type_char(logic [7:0] ch);
		int unsigned cols;
		int unsigned rows;
		int unsigned c;
		cols = live_columns();
		rows = live_rows();
		if (ch == CH_NEWLINE) begin
			col_ptr = 0;
			row_ptr++;
		end else if (ch == CH_BACKSPACE) begin
			if (col_ptr > 0) begin
				col_ptr--;
				paint_cell(physical_row(row_ptr), col_ptr, CH_BLANK);
			end
		end else begin
			paint_cell(physical_row(row_ptr), col_ptr, ch);
			col_ptr++;
			if (col_ptr >= cols) begin
				col_ptr = 0;
				row_ptr++;
			end
		end
		// blank the oldest line and scroll up
		if (row_ptr >= rows) begin
			for (c = 0; c < cols; c++) paint_cell(top_row, c, CH_BLANK);
			top_row++;
			if (top_row >= rows) top_row = 0;
			row_ptr--;
		end
	endfunction

	function automatic console_result_t compute_cursor_and_cell(logic [2:0] cmd, logic [7:0] vb,
			logic [7:0] ri, logic [31:0] colr, logic [1:0] mode);
		console_result_t r;
		int unsigned cols;
		int unsigned rows;
		int unsigned idx;
		cols = live_columns();
		rows = live_rows();
		r = '0;
		case (cmd)
			CMD_PUT_CHAR: type_char(vb);
			CMD_SET_COLOR: pen = colr;
			CMD_SET_CURSOR: begin
				col_ptr = (vb >= cols) ? cols - 1 : vb;
				row_ptr = (ri >= rows) ? rows - 1 : ri;
			end
			CMD_CLEAR: begin
				if (mode == FULL_CLEAR) begin
					blank_store();
					col_ptr = 0;
					row_ptr = 0;
					top_row = 0;
				end
			end
			CMD_READ_CELL: begin
				if (vb < cols && ri < rows) begin
					idx = physical_row(ri) * MAX_COLUMNS + vb;
					r.cell_glyph = glyph_mem[idx];
					r.cell_fg = fore_mem[idx];
					r.cell_bg = back_mem[idx];
				end
			end
			default: ;
		endcase
		r.cursor_row = row_ptr[5:0];
		r.cursor_col = col_ptr[6:0];
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (seen !== want) begin
			$error("%s expected %h, got %h", name, want, seen);
			mismatches++;
		end
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) return CH_NEWLINE;
		if (r < 20) return CH_BACKSPACE;
		if (r < 90) return 8'($urandom_range(8'h21, 8'h7E));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_request(logic [2:0] cmd, logic [7:0] vb, logic [7:0] ri,
			logic [31:0] colr, logic [1:0] mode);
		int gap;
		gap = source_idle ? $urandom_range(0, 17) : 0;
		pending_readbacks.push_back(compute_cursor_and_cell(cmd, vb, ri, colr, mode));
		if (cmd == CMD_CLEAR && mode == FULL_CLEAR) full_clears++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'b0, mode, colr, ri, vb};
		do @(posedge clk); while (!s_tready);
		requests_sent++;
	endtask

	task automatic send_random_request(bit text_heavy);
		int pick;
		int unsigned cols;
		int unsigned rows;
		logic [2:0] cmd;
		logic [7:0] vb;
		logic [7:0] ri;
		logic [31:0] colr;
		logic [1:0] mode;
		cols = live_columns();
		rows = live_rows();
		pick = $urandom_range(0, 99);
		colr = $urandom();
		mode = 2'($urandom_range(0, 3));
		vb = 8'($urandom_range(0, 255));
		ri = 8'($urandom_range(0, 255));
		if (pick < (text_heavy ? 70 : 45)) begin
			cmd = CMD_PUT_CHAR;
			vb = pick_char();
		end else if (pick < (text_heavy ? 76 : 55)) begin
			cmd = CMD_SET_COLOR;
		end else if (pick < (text_heavy ? 82 : 67)) begin
			cmd = CMD_SET_CURSOR;
			if ($urandom_range(0, 9) < 7) begin
				vb = 8'($urandom_range(0, cols - 1));
				ri = 8'($urandom_range(0, rows - 1));
			end
		end else if (pick < (text_heavy ? 85 : 72)) begin
			cmd = CMD_CLEAR;
		end else if (pick < (text_heavy ? 98 : 95)) begin
			cmd = CMD_READ_CELL;
			if ($urandom_range(0, 9) < 8) begin
				vb = 8'($urandom_range(0, cols - 1));
				ri = 8'($urandom_range(0, rows - 1));
			end
		end else begin
			cmd = 3'($urandom_range(CMD_READ_CELL + 1, 7));
		end
		send_request(cmd, vb, ri, colr, mode);
	endtask

	task automatic send_random_burst(int count, bit text_heavy);
		repeat (count) send_random_request(text_heavy);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_results_drained();
		while (pending_readbacks.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [31:0] value);
		case (index)
			REG_COLUMNS: begin
				columns_reg = value[7:0];
				fit_cursor();
			end
			REG_ROWS: begin
				rows_reg = value[6:0];
				fit_cursor();
			end
			REG_BACKGROUND: background_reg = value;
			default: ;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfigure(logic [7:0] cols, logic [6:0] rows, logic [31:0] bg);
		stop_sending();
		wait_results_drained();
		// let any store sweep finish
		repeat (SWEEP_CYCLES) @(posedge clk);
		write_register(REG_COLUMNS, {24'b0, cols});
		write_register(REG_ROWS, {25'b0, rows});
		write_register(REG_BACKGROUND, bg);
		size_settings++;
	endtask

	task automatic test_directed_corners();
		source_idle = 1'b0;
		sink_idle = 1'b0;
		send_request(CMD_READ_CELL, 8'd0, 8'd0, 32'd0, 2'd0);
		send_request(CMD_PUT_CHAR, 8'h41, 8'd0, 32'd0, 2'd0);
		send_request(CMD_PUT_CHAR, 8'h00, 8'd0, 32'd0, 2'd0);
		send_request(CMD_PUT_CHAR, 8'hFF, 8'hFF, 32'd0, 2'd0);
		send_request(CMD_SET_COLOR, 8'd0, 8'd0, 32'hFFFF_FFFF, 2'd0);
		send_request(CMD_PUT_CHAR, 8'h42, 8'd0, 32'd0, 2'd0);
		send_request(CMD_SET_COLOR, 8'd0, 8'd0, 32'h0000_0000, 2'd0);
		send_request(CMD_PUT_CHAR, 8'h43, 8'd0, 32'd0, 2'd0);
		send_request(CMD_READ_CELL, 8'd2, 8'd0, 32'd0, 2'd0);
		send_request(CMD_READ_CELL, 8'd3, 8'd0, 32'd0, 2'd0);
		send_request(CMD_PUT_CHAR, CH_BACKSPACE, 8'd0, 32'd0, 2'd0);
		send_request(CMD_READ_CELL, 8'd4, 8'd0, 32'd0, 2'd0);
		send_request(CMD_PUT_CHAR, CH_NEWLINE, 8'd0, 32'd0, 2'd0);
		send_request(CMD_PUT_CHAR, CH_BACKSPACE, 8'd0, 32'd0, 2'd0);
		send_request(CMD_SET_CURSOR, 8'hFF, 8'hFF, 32'd0, 2'd0);
		send_request(CMD_PUT_CHAR, 8'h5A, 8'd0, 32'd0, 2'd0);
		send_request(CMD_READ_CELL, 8'd74, 8'd48, 32'd0, 2'd0);
		send_request(CMD_SET_CURSOR, 8'd10, 8'd3, 32'd0, 2'd0);
		send_request(CMD_CLEAR, 8'd0, 8'd0, 32'd0, 2'd0);
		send_request(CMD_CLEAR, 8'd0, 8'd0, 32'd0, 2'd1);
		send_request(CMD_CLEAR, 8'd0, 8'd0, 32'd0, 2'd3);
		send_request(CMD_READ_CELL, 8'hFF, 8'hFF, 32'd0, 2'd0);
		send_request(CMD_READ_CELL, 8'd75, 8'd0, 32'd0, 2'd0);
		send_request(CMD_READ_CELL, 8'd0, 8'd50, 32'd0, 2'd0);
		send_request(3'(CMD_READ_CELL + 1), 8'd1, 8'd1, 32'd0, 2'd0);
		send_request(3'(CMD_READ_CELL + 2), 8'd1, 8'd1, 32'd0, 2'd0);
		send_request(3'(CMD_READ_CELL + 3), 8'd1, 8'd1, 32'd0, 2'd0);
		send_request(CMD_CLEAR, 8'd0, 8'd0, 32'd0, FULL_CLEAR);
		send_request(CMD_READ_CELL, 8'd0, 8'd0, 32'd0, 2'd0);
	endtask

	task automatic test_wrap_and_scroll();
		reconfigure(8'd4, 7'd3, $urandom());
		source_idle = 1'b1;
		sink_idle = 1'b1;
		send_random_burst(80, 1'b1);
	endtask

	task automatic test_size_extremes();
		logic [7:0] col_set [5];
		logic [6:0] row_set [5];
		int i;
		col_set = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0};
		row_set = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd0};
		col_set[4] = 8'($urandom_range(2, 127));
		row_set[4] = 7'($urandom_range(2, 63));
		for (i = 0; i < 5; i++) begin
			reconfigure(col_set[i], row_set[i],
				(i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom());
			source_idle = 1'($urandom_range(0, 1));
			sink_idle = 1'($urandom_range(0, 1));
			send_random_burst(30, 1'(i % 2));
		end
	endtask

	task automatic test_output_backpressure();
		source_idle = 1'b0;
		sink_idle = 1'b0;
		hold_off_cycles = 300;
		send_random_burst(24, 1'b1);
	endtask

	task automatic test_input_pause();
		source_idle = 1'b1;
		sink_idle = 1'b1;
		send_random_burst(15, 1'b0);
		stop_sending();
		wait_results_drained();
		send_random_burst(15, 1'b1);
	endtask

	task automatic test_random_mix();
		int chunk;
		reconfigure(8'($urandom_range(1, 255)), 7'($urandom_range(1, 127)), $urandom());
		for (chunk = 0; chunk < 4; chunk++) begin
			source_idle = 1'($urandom_range(0, 1));
			sink_idle = 1'($urandom_range(0, 1));
			send_random_burst(30, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			stall = sink_idle ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : check_results
		console_result_t seen;
		console_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[$bits(console_result_t)-1:0];
			results_checked++;
			if (pending_readbacks.size() == 0) begin
				$error("result with no request waiting: %h", seen);
				mismatches++;
			end else begin
				want = pending_readbacks.pop_front();
				compare_field("cursor_row", want.cursor_row, seen.cursor_row);
				compare_field("cursor_col", want.cursor_col, seen.cursor_col);
				compare_field("cell_glyph", want.cell_glyph, seen.cell_glyph);
				compare_field("cell_fg", want.cell_fg, seen.cell_fg);
				compare_field("cell_bg", want.cell_bg, seen.cell_bg);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		columns_reg = COLUMNS_RESET;
		rows_reg = ROWS_RESET;
		background_reg = BACKGROUND_RESET;
		pen = WHITE_PIXEL;
		row_ptr = 0;
		col_ptr = 0;
		top_row = 0;
		blank_store();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// hold until the power-up sweep is done
		do @(posedge clk); while (!s_tready);
		test_directed_corners();
		test_wrap_and_scroll();
		test_size_extremes();
		test_output_backpressure();
		test_input_pause();
		test_random_mix();
		stop_sending();
		wait_results_drained();
		repeat (MAX_COLUMNS + 16) @(posedge clk);
		if (pending_readbacks.size() != 0) begin
			$error("%0d results never arrived", pending_readbacks.size());
			mismatches++;
		end
		$display("Ran %0d requests, checked %0d results over %0d size settings, %0d full clears.",
			requests_sent, results_checked, size_settings, full_clears);
		$display("Exercised wrap, scroll, backspace, cursor clamping, reads outside the console.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
rtl/tcw_pkg.sv
rtl/tcw_regs.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_cell_writer.sv
bench/testbench.sv
